>>> rtl/core/acb_pkg.sv
// Shared types, constants and the Ascon round function for the single-block encryptor.
package acb_pkg;

    typedef logic [63:0]      t_word;
    typedef t_word [4:0]      t_state;   // index 0 is the first state word
    typedef t_word [1:0]      t_aux;     // plaintext words, replaced by ciphertext words
    typedef logic [1:0]       t_cfg_idx;
    typedef logic [7:0]       t_rc;
    typedef t_rc              t_rc_table [12];

    typedef struct packed {
        t_word cipher_high;
        t_word cipher_low;
        t_word tag_high;
        t_word tag_low;
    } t_result;

    // register indexes on the config port
    localparam t_cfg_idx CFG_KEY_HIGH    = 2'd0;
    localparam t_cfg_idx CFG_KEY_LOW     = 2'd1;
    localparam t_cfg_idx CFG_INIT_VECTOR = 2'd2;

    localparam t_word IV_RESET = 64'h8040_0C06_0000_0000;
    localparam t_word PAD_BIT  = 64'h8000_0000_0000_0000;
    localparam t_word DSEP_BIT = 64'h0000_0000_0000_0001;

    // round stages: p12 init, p6 after first word, p6 after second word, p12 final
    localparam int unsigned NUM_STAGES  = 36;
    localparam int unsigned STAGE_WORD0 = 12;
    localparam int unsigned STAGE_WORD1 = 18;
    localparam int unsigned STAGE_FINAL = 24;

    localparam t_rc_table ROUND_CONST = '{
        8'hf0, 8'he1, 8'hd2, 8'hc3, 8'hb4, 8'ha5,
        8'h96, 8'h87, 8'h78, 8'h69, 8'h5a, 8'h4b
    };

    // position in the 12-round constant schedule for a given stage
    function automatic int unsigned rc_pos(int unsigned idx);
        if (idx < STAGE_WORD0) begin
            return idx;
        end else if (idx < STAGE_FINAL) begin
            return 6 + ((idx - STAGE_WORD0) % 6);
        end else begin
            return idx - STAGE_FINAL;
        end
    endfunction

    // constant addition, S-box layer, linear diffusion
    function automatic t_state ascon_round(t_state w, t_rc c);
        t_word a0, a1, a2, a3, a4;
        t_word b0, b1, b2, b3, b4;
        t_state r;
        a0 = w[0] ^ w[4];
        a4 = w[4] ^ w[3];
        a2 = w[2] ^ {56'd0, c} ^ w[1];
        a1 = w[1];
        a3 = w[3];
        b0 = ~a0 & a1;
        b1 = ~a1 & a2;
        b2 = ~a2 & a3;
        b3 = ~a3 & a4;
        b4 = ~a4 & a0;
        a0 = a0 ^ b1;
        a1 = a1 ^ b2;
        a2 = a2 ^ b3;
        a3 = a3 ^ b4;
        a4 = a4 ^ b0;
        a1 = a1 ^ a0;
        a0 = a0 ^ a4;
        a3 = a3 ^ a2;
        a2 = ~a2;
        r[0] = a0 ^ {a0[18:0], a0[63:19]} ^ {a0[27:0], a0[63:28]};
        r[1] = a1 ^ {a1[60:0], a1[63:61]} ^ {a1[38:0], a1[63:39]};
        r[2] = a2 ^ {a2[0],    a2[63:1]}  ^ {a2[5:0],  a2[63:6]};
        r[3] = a3 ^ {a3[9:0],  a3[63:10]} ^ {a3[16:0], a3[63:17]};
        r[4] = a4 ^ {a4[6:0],  a4[63:7]}  ^ {a4[40:0], a4[63:41]};
        return r;
    endfunction

endpackage

>>> rtl/core/acb_if.sv
// Channel interfaces: input words, result words and register writes.
interface acb_in_if;
    import acb_pkg::*;
    logic  valid;
    logic  ready;
    t_word nonce_high;
    t_word nonce_low;
    t_word plain_high;
    t_word plain_low;
    modport source (output valid, nonce_high, nonce_low, plain_high, plain_low, input ready);
    modport sink   (input valid, nonce_high, nonce_low, plain_high, plain_low, output ready);
endinterface

interface acb_out_if;
    import acb_pkg::*;
    logic  valid;
    logic  ready;
    t_word cipher_high;
    t_word cipher_low;
    t_word tag_high;
    t_word tag_low;
    modport source (output valid, cipher_high, cipher_low, tag_high, tag_low, input ready);
    modport sink   (input valid, cipher_high, cipher_low, tag_high, tag_low, output ready);
endinterface

interface acb_cfg_if;
    import acb_pkg::*;
    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_word    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/acb_stage.sv
// One pipeline stage: optional key/data mixing, then one Ascon round, then registers.
module acb_stage #(
    parameter int unsigned P_IDX = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  acb_pkg::t_state i_state,
    input  acb_pkg::t_aux   i_aux,
    input  acb_pkg::t_word  i_key_high,
    input  acb_pkg::t_word  i_key_low,
    output logic          o_valid,
    output acb_pkg::t_state o_state,
    output acb_pkg::t_aux   o_aux
);
    import acb_pkg::*;

    localparam int unsigned P_POS = rc_pos(P_IDX);

    logic   r_valid;
    t_state r_state;
    t_aux   r_aux;
    t_state mix_state;
    t_aux   n_aux;
    t_state n_state;

    always_comb begin
        mix_state = i_state;
        n_aux     = i_aux;
        if (P_IDX == STAGE_WORD0) begin
            // end of init: key mix, domain separation, absorb first word
            mix_state[3] = i_state[3] ^ i_key_high;
            mix_state[4] = i_state[4] ^ i_key_low ^ DSEP_BIT;
            mix_state[0] = i_state[0] ^ i_aux[0];
            n_aux[0]     = mix_state[0];
        end
        if (P_IDX == STAGE_WORD1) begin
            mix_state[0] = i_state[0] ^ i_aux[1];
            n_aux[1]     = mix_state[0];
        end
        if (P_IDX == STAGE_FINAL) begin
            // empty padded block, then key mix ahead of final p12
            mix_state[0] = i_state[0] ^ PAD_BIT;
            mix_state[1] = i_state[1] ^ i_key_high;
            mix_state[2] = i_state[2] ^ i_key_low;
        end
        n_state = ascon_round(mix_state, ROUND_CONST[P_POS]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= n_state;
            r_aux   <= n_aux;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_aux   = r_aux;

endmodule

>>> rtl/core/acb_out.sv
// Final key mix into the tag, output register and skid register.
module acb_out (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  acb_pkg::t_state i_state,
    input  acb_pkg::t_aux   i_aux,
    input  acb_pkg::t_word  i_key_high,
    input  acb_pkg::t_word  i_key_low,
    output logic            o_en,
    acb_out_if.source       o_out
);
    import acb_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    t_result n_res;
    logic    push;
    logic    out_free;

    assign n_res.cipher_high = i_aux[0];
    assign n_res.cipher_low  = i_aux[1];
    assign n_res.tag_high    = i_state[3] ^ i_key_high;
    assign n_res.tag_low     = i_state[4] ^ i_key_low;

    assign o_en     = !r_skid_valid;
    assign push     = i_valid && !r_skid_valid;
    assign out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= push;
            end
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : n_res;
        end else if (push) begin
            r_skid <= n_res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.cipher_high = r_out.cipher_high;
    assign o_out.cipher_low  = r_out.cipher_low;
    assign o_out.tag_high    = r_out.tag_high;
    assign o_out.tag_low     = r_out.tag_low;

endmodule

>>> rtl/core/ascon128_single_block_encrypt_core.sv
// Top level: Ascon-128 single-block encryptor, one round per pipeline stage.
//
// Usage:
//   i_cfg  : register writes. index 0 = key high word, 1 = key low word,
//            2 = IV. Other indexes are dropped. Always ready. Write only
//            while no word is in flight.
//   i_in   : one word = nonce (two 64-bit halves) + 128-bit plaintext,
//            all big-endian. Accepted when valid && ready.
//   o_out  : one word per input word: ciphertext halves and 128-bit tag,
//            in input order.
// Path: 36 round stages, p12 + p6 + p6 + p12, the first loading at the
//   accepting edge, then the output register ahead of o_out.valid.
// Throughput: one word per cycle while the skid register is empty; the
//   36 unrolled rounds each own a register stage, so the round logic
//   sets the clock, not the rate.
// Reset: pipeline and output empty, key cleared, IV back to the standard
//   Ascon-128 value.
// Stall: when o_out is held off, the next result lands in a skid register
//   and the input keeps flowing for that cycle; once the skid is full the
//   whole pipeline freezes and i_in.ready drops, nothing lost or repeated.
//   Ready stays low for the cycle in which the skid moves to the output.
module ascon128_single_block_encrypt_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    acb_in_if.sink     i_in,
    acb_cfg_if.sink    i_cfg,
    acb_out_if.source  o_out
);
    import acb_pkg::*;

    t_word  r_key_high;
    t_word  r_key_low;
    t_word  r_init_vector;
    logic   en;

    // stage chain; entry 0 is the input, entry k the output of stage k-1
    logic   stg_valid [NUM_STAGES + 1];
    t_state stg_state [NUM_STAGES + 1];
    t_aux   stg_aux   [NUM_STAGES + 1];

    // config registers, written only while idle by the user; not enforced
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high    <= '0;
            r_key_low     <= '0;
            r_init_vector <= IV_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_KEY_HIGH:    r_key_high    <= i_cfg.data;
                CFG_KEY_LOW:     r_key_low     <= i_cfg.data;
                CFG_INIT_VECTOR: r_init_vector <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // pipeline advances unless the skid register is occupied
    assign i_in.ready = en;

    // initial state: IV || key || nonce
    assign stg_valid[0]    = i_in.valid;
    assign stg_state[0][0] = r_init_vector;
    assign stg_state[0][1] = r_key_high;
    assign stg_state[0][2] = r_key_low;
    assign stg_state[0][3] = i_in.nonce_high;
    assign stg_state[0][4] = i_in.nonce_low;
    assign stg_aux[0][0]   = i_in.plain_high;
    assign stg_aux[0][1]   = i_in.plain_low;

    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
        acb_stage #(
            .P_IDX (g)
        ) u_stage (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (en),
            .i_valid    (stg_valid[g]),
            .i_state    (stg_state[g]),
            .i_aux      (stg_aux[g]),
            .i_key_high (r_key_high),
            .i_key_low  (r_key_low),
            .o_valid    (stg_valid[g + 1]),
            .o_state    (stg_state[g + 1]),
            .o_aux      (stg_aux[g + 1])
        );
    end

    acb_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (stg_valid[NUM_STAGES]),
        .i_state    (stg_state[NUM_STAGES]),
        .i_aux      (stg_aux[NUM_STAGES]),
        .i_key_high (r_key_high),
        .i_key_low  (r_key_low),
        .o_en       (en),
        .o_out      (o_out)
    );

endmodule

>>> tb/sv/tb_ascon128_single_block_encrypt_core.sv
// Self-checking testbench for the Ascon-128 single-block encryptor core.
`timescale 1ns / 1ps

module tb_ascon128_single_block_encrypt_core;
    import acb_pkg::*;

    // ------------------------------------------------------------------
    // Constants
    // ------------------------------------------------------------------
    localparam int unsigned PIPE_LATENCY = 36;         // round stages between acceptance and the output register
    localparam t_word       ALL_ONES     = {64{1'b1}};
    localparam t_word       DOMAIN_SEP   = 64'd1;      // after init, last state word
    localparam t_word       PAD_WORD     = 64'h8000_0000_0000_0000;
    localparam t_cfg_idx    CFG_SPARE    = 2'd3;       // unmapped index, must be dropped

    // one input word as it sits in the send queue
    typedef struct packed {
        t_word nonce_high;
        t_word nonce_low;
        t_word plain_high;
        t_word plain_low;
    } t_plain_block;

    // ------------------------------------------------------------------
    // Clock, reset and the three channels
    // ------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #5 i_clk = ~i_clk;

    acb_in_if  in_ch ();
    acb_cfg_if cfg_ch ();
    acb_out_if out_ch ();

    // Testbench-owned copies of every block input, known from time zero.
    logic  in_valid   = 1'b0;
    t_word in_nh      = '0;
    t_word in_nl      = '0;
    t_word in_ph      = '0;
    t_word in_pl      = '0;
    logic  out_ready  = 1'b0;
    logic  cfg_valid  = 1'b0;
    t_cfg_idx cfg_idx = CFG_KEY_HIGH;
    t_word cfg_data   = '0;

    assign in_ch.valid      = in_valid;
    assign in_ch.nonce_high = in_nh;
    assign in_ch.nonce_low  = in_nl;
    assign in_ch.plain_high = in_ph;
    assign in_ch.plain_low  = in_pl;
    assign out_ch.ready     = out_ready;
    assign cfg_ch.valid     = cfg_valid;
    assign cfg_ch.index     = cfg_idx;
    assign cfg_ch.data      = cfg_data;

    ascon128_single_block_encrypt_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    // ------------------------------------------------------------------
    // Predictor: Ascon permutation and the one-block encryption flow
    // ------------------------------------------------------------------
    function automatic t_word rotr(t_word v, int unsigned n);
        return (v >> n) | (v << (64 - n));
    endfunction

    // Round r of the 12-round schedule; the constant's high nibble counts
    // down from f while the low nibble counts up from 0.
    function automatic t_state perm_round(t_state s, int unsigned r);
        t_word x0, x1, x2, x3, x4;
        t_word t0, t1, t2, t3, t4;
        t_rc   rc;
        t_state o;
        rc = {4'hf - 4'(r), 4'(r)};
        x0 = s[0] ^ s[4];
        x4 = s[4] ^ s[3];
        x2 = s[2] ^ {56'd0, rc} ^ s[1];
        x1 = s[1];
        x3 = s[3];
        t0 = ~x0 & x1;
        t1 = ~x1 & x2;
        t2 = ~x2 & x3;
        t3 = ~x3 & x4;
        t4 = ~x4 & x0;
        x0 = x0 ^ t1;
        x1 = x1 ^ t2;
        x2 = x2 ^ t3;
        x3 = x3 ^ t4;
        x4 = x4 ^ t0;
        x1 = x1 ^ x0;
        x0 = x0 ^ x4;
        x3 = x3 ^ x2;
        x2 = ~x2;
        o[0] = x0 ^ rotr(x0, 19) ^ rotr(x0, 28);
        o[1] = x1 ^ rotr(x1, 61) ^ rotr(x1, 39);
        o[2] = x2 ^ rotr(x2, 1)  ^ rotr(x2, 6);
        o[3] = x3 ^ rotr(x3, 10) ^ rotr(x3, 17);
        o[4] = x4 ^ rotr(x4, 7)  ^ rotr(x4, 41);
        return o;
    endfunction

    // last 'rounds' rounds of the schedule (p12 or p6)
    function automatic t_state ascon_perm(t_state s, int unsigned rounds);
        for (int unsigned r = 12 - rounds; r < 12; r++) begin
            s = perm_round(s, r);
        end
        return s;
    endfunction

    // Register mirror, tracked from accepted config writes.
    t_word key_hi_m = '0;
    t_word key_lo_m = '0;
    t_word iv_m     = IV_RESET;

    function automatic t_result seal_block(t_plain_block b);
        t_state  s;
        t_result r;
        // init: IV | key | nonce, p12, key into the tail
        s[0] = iv_m;
        s[1] = key_hi_m;
        s[2] = key_lo_m;
        s[3] = b.nonce_high;
        s[4] = b.nonce_low;
        s = ascon_perm(s, 12);
        s[3] = s[3] ^ key_hi_m;
        s[4] = s[4] ^ key_lo_m ^ DOMAIN_SEP;
        // two plaintext words, each followed by p6
        s[0] = s[0] ^ b.plain_high;
        r.cipher_high = s[0];
        s = ascon_perm(s, 6);
        s[0] = s[0] ^ b.plain_low;
        r.cipher_low = s[0];
        s = ascon_perm(s, 6);
        // empty padded last block, then finalization
        s[0] = s[0] ^ PAD_WORD;
        s[1] = s[1] ^ key_hi_m;
        s[2] = s[2] ^ key_lo_m;
        s = ascon_perm(s, 12);
        r.tag_high = s[3] ^ key_hi_m;
        r.tag_low  = s[4] ^ key_lo_m;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Bookkeeping
    // ------------------------------------------------------------------
    t_plain_block block_queue[$];     // waiting to be sent
    t_result      sealed_expect[$];   // predicted, waiting for o_out
    int unsigned  words_sent    = 0;
    int unsigned  words_checked = 0;
    int unsigned  cfg_writes    = 0;
    int unsigned  mismatches    = 0;

    // per-phase idle rates: 0 = never idle, N = start a burst with a chance of 1 in N
    int unsigned  in_idle_rate  = 0;
    int unsigned  out_idle_rate = 0;

    // ------------------------------------------------------------------
    // Input driver: falling edge. Valid stays up until the word is taken;
    // gaps only open between words.
    // ------------------------------------------------------------------
    bit          in_taken = 1'b0;   // set at the rising edge that took a word
    int unsigned gap_left = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !in_taken) begin
            // holding the current word until it is accepted
        end else begin
            in_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (in_idle_rate != 0 && $urandom_range(1, in_idle_rate) == 1) begin
                gap_left = $urandom_range(0, 18);   // start an idle burst
                in_valid <= 1'b0;
            end else if (block_queue.size() != 0) begin
                in_valid <= 1'b1;
                in_nh    <= block_queue[0].nonce_high;
                in_nl    <= block_queue[0].nonce_low;
                in_ph    <= block_queue[0].plain_high;
                in_pl    <= block_queue[0].plain_low;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result sink: falling edge, random stall bursts on ready.
    // ------------------------------------------------------------------
    int unsigned stall_left = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (out_idle_rate != 0 && $urandom_range(1, out_idle_rate) == 1) begin
            stall_left = $urandom_range(0, 18);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Rising edge: register mirror and prediction of accepted words.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_hi_m = '0;
            key_lo_m = '0;
            iv_m     = IV_RESET;
        end else begin
            if (cfg_valid && cfg_ch.ready) begin
                cfg_writes++;
                case (cfg_idx)
                    CFG_KEY_HIGH:    key_hi_m = cfg_data;
                    CFG_KEY_LOW:     key_lo_m = cfg_data;
                    CFG_INIT_VECTOR: iv_m     = cfg_data;
                    default: ;      // unmapped index: dropped by the core
                endcase
            end
            if (in_valid && in_ch.ready) begin
                sealed_expect.push_back(seal_block({in_nh, in_nl, in_ph, in_pl}));
                void'(block_queue.pop_front());
                in_taken = 1'b1;
                words_sent++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Rising edge: compare each delivered word with the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        logic [3:0] diff;
        if (i_rst_n && out_ch.valid && out_ready) begin
            got = {out_ch.cipher_high, out_ch.cipher_low, out_ch.tag_high, out_ch.tag_low};
            if (sealed_expect.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result word: %h", got);
                end
            end else begin
                want = sealed_expect.pop_front();
                diff = {got.cipher_high !== want.cipher_high,
                        got.cipher_low  !== want.cipher_low,
                        got.tag_high    !== want.tag_high,
                        got.tag_low     !== want.tag_low};
                if (diff != 4'b0000) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        // field mask order: cipher_high cipher_low tag_high tag_low
                        $display("word %0d mismatch, fields %b\n  exp %h %h %h %h\n  got %h %h %h %h",
                                 words_checked, diff,
                                 want.cipher_high, want.cipher_low, want.tag_high, want.tag_low,
                                 got.cipher_high, got.cipher_low, got.tag_high, got.tag_low);
                    end
                end
            end
            words_checked++;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing helpers
    // ------------------------------------------------------------------
    // One register write; the core is only written while idle.
    task automatic write_reg(t_cfg_idx idx, t_word val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_idx   <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_setting(t_word kh, t_word kl, t_word iv);
        write_reg(CFG_KEY_HIGH, kh);
        write_reg(CFG_KEY_LOW, kl);
        write_reg(CFG_INIT_VECTOR, iv);
    endtask

    // Corner-heavy 64-bit values: zero, all ones, walking ones and zeros, random.
    function automatic t_word rand_word();
        int unsigned k;
        k = $urandom_range(0, 63);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return t_word'(1) << k;
            3:       return ~(t_word'(1) << k);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic t_word rand_full();
        return {$urandom, $urandom};
    endfunction

    task automatic queue_random(int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            block_queue.push_back({rand_word(), rand_word(), rand_word(), rand_word()});
        end
    endtask

    // Sender holds off until every predicted word is back, then the pipe
    // gets its latency to empty out before any register write.
    task automatic settle();
        while (block_queue.size() != 0 || sealed_expect.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_LATENCY + 3) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, reset key and IV: field extremes and simple patterns.
        in_idle_rate  = 5;
        out_idle_rate = 5;
        block_queue.push_back(t_plain_block'('0));
        block_queue.push_back({ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES});
        block_queue.push_back({ALL_ONES, ALL_ONES, t_word'('0), t_word'('0)});
        block_queue.push_back({t_word'('0), t_word'('0), ALL_ONES, ALL_ONES});
        block_queue.push_back({64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555,
                               64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa});
        block_queue.push_back({PAD_WORD, DOMAIN_SEP, DOMAIN_SEP, PAD_WORD});
        block_queue.push_back({64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f,
                               64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff});
        // same word twice in a row: results must not depend on history
        block_queue.push_back(t_plain_block'('0));
        block_queue.push_back(t_plain_block'('0));
        settle();

        // Key all ones, standard IV; a write to the unmapped index must be dropped.
        load_setting(ALL_ONES, ALL_ONES, IV_RESET);
        write_reg(CFG_SPARE, rand_full());
        block_queue.push_back(t_plain_block'('0));
        block_queue.push_back({ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES});
        block_queue.push_back({ALL_ONES, t_word'('0), ALL_ONES, t_word'('0)});
        queue_random(6);
        settle();

        // Random phases with different idle mixes.
        in_idle_rate  = 6;
        out_idle_rate = 6;
        queue_random(350);
        settle();

        // random key and IV, heavy sender gaps
        load_setting(rand_full(), rand_full(), rand_full());
        write_reg(CFG_SPARE, ALL_ONES);
        in_idle_rate  = 3;
        out_idle_rate = 8;
        queue_random(400);
        settle();

        // zero key half / zero IV; sender never idles so receiver stalls
        // fill the skid register and freeze the pipe
        load_setting('0, ALL_ONES, '0);
        in_idle_rate  = 0;
        out_idle_rate = 4;
        queue_random(350);
        settle();

        // IV all ones; receiver always ready, sender bursty
        load_setting(rand_full(), rand_full(), ALL_ONES);
        in_idle_rate  = 4;
        out_idle_rate = 0;
        queue_random(400);
        settle();

        // Final stretch at full rate on both sides.
        load_setting(rand_full(), rand_full(), IV_RESET);
        in_idle_rate  = 0;
        out_idle_rate = 0;
        queue_random(400);
        settle();

        mismatches += sealed_expect.size();
        $display("covered %0d words, %0d results checked, %0d register writes, 6 key/IV sets",
                 words_sent, words_checked, cfg_writes);
        $display("stalls on both sides incl. full-pipe freeze, unmapped register index, full-rate tail");
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (about 2k words, the longest
    // gaps and stalls on each, pipeline latency, config writes).
    initial begin
        #5_000_000;
        $display("timeout after %0d of %0d results", words_checked, words_sent);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
